/* src/pmi_pkg.sv */
// ----------------------------------------------------------------------------
// pmi_pkg
// types and constants for the palindrome minimum insertions block
// ----------------------------------------------------------------------------
package pmi_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int SYMBOL_W    = 8;
    localparam int INS_W       = 6;
    localparam int LCS_W       = 7;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [INS_W-1:0] insertions;
        logic [LCS_W-1:0] lcs_length;
        logic             overflow;
    } result_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROW_RD,
        ST_ROW_SYM,
        ST_CELL
    } state_t;

endpackage

/* src/pmi_ram.sv */
// ----------------------------------------------------------------------------
// pmi_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pmi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/pmi_cell.sv */
// ----------------------------------------------------------------------------
// pmi_cell
// shared lcs table cell: compare two bytes, then diagonal plus one or max
// ----------------------------------------------------------------------------
module pmi_cell #(
    parameter int VW = 7
) (
    input  logic [pmi_pkg::SYMBOL_W-1:0] row_sym,
    input  logic [pmi_pkg::SYMBOL_W-1:0] col_sym,
    input  logic [VW-1:0]                above,
    input  logic [VW-1:0]                left,
    input  logic [VW-1:0]                diag,
    output logic [VW-1:0]                value
);

    import pmi_pkg::*;

    always_comb
    begin
        if (row_sym == col_sym)
        begin
            value = diag + VW'(1);
        end
        else if (left > above)
        begin
            value = left;
        end
        else
        begin
            value = above;
        end
    end

endmodule

/* src/palindrome_min_insertions.sv */
// the bytes are stored first, then the table is swept one cell per cycle
// within a row through a single compare/max unit, limited by one read port
// each on the byte ram and the row ram; no byte is taken during the sweep,
// and a last byte also waits until the previous result beat is taken
// reset: rst_n clears count, overflow, sequencer and result valid at once;
// ----------------------------------------------------------------------------
// palindrome_min_insertions
// stores a byte string, sweeps the lcs table of string and reverse over one
// rolling row, and returns lcs length and minimum palindrome insertions;
// the rams need no clearing
// ----------------------------------------------------------------------------
module palindrome_min_insertions #(
    parameter int MAX_LEN = pmi_pkg::MAX_LEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pmi_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output pmi_pkg::result_t result
);

    import pmi_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int WW = (CW > LCS_W) ? CW : LCS_W;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic                res_ovf_reg, res_ovf_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [SYMBOL_W-1:0] row_sym_reg, row_sym_next;
    logic [CW-1:0]       diag_reg, diag_next;
    logic [CW-1:0]       left_reg, left_next;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    logic                accept;
    logic                txt_wr_en;
    logic [AW-1:0]       txt_rd_addr;
    logic [SYMBOL_W-1:0] txt_rd_data;
    logic                dp_wr_en;
    logic [AW-1:0]       dp_rd_addr;
    logic [CW-1:0]       dp_rd_data;
    logic [CW-1:0]       above;
    logic [CW-1:0]       cell_value;
    logic [WW-1:0]       lcs_wide;
    logic [WW-1:0]       ins_wide;

    // a last byte waits while the previous result is still pending
    assign item_stall = (state_reg != ST_LOAD) || (result_valid_reg && item.last);
    assign accept     = item_valid && !item_stall;
    assign txt_wr_en  = accept && (count_reg < CW'(MAX_LEN));

    // first row reads zeros above instead of the row ram
    assign above = (i_reg == CW'(1)) ? '0 : dp_rd_data;

    assign dp_wr_en = (state_reg == ST_CELL);

    pmi_ram #(
        .WIDTH (SYMBOL_W),
        .DEPTH (MAX_LEN)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (txt_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (item.symbol),
        .rd_addr (txt_rd_addr),
        .rd_data (txt_rd_data)
    );

    // row entry j lives at address j-1
    pmi_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_LEN)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (dp_wr_en),
        .wr_addr (AW'(j_reg - CW'(1))),
        .wr_data (cell_value),
        .rd_addr (dp_rd_addr),
        .rd_data (dp_rd_data)
    );

    pmi_cell #(
        .VW (CW)
    ) u_cell (
        .row_sym (row_sym_reg),
        .col_sym (txt_rd_data),
        .above   (above),
        .left    (left_reg),
        .diag    (diag_reg),
        .value   (cell_value)
    );

    assign lcs_wide = WW'(cell_value);
    assign ins_wide = WW'(len_reg - cell_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_ovf_reg <= res_ovf_next;
        len_reg     <= len_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        row_sym_reg <= row_sym_next;
        diag_reg    <= diag_next;
        left_reg    <= left_next;
        result_reg  <= result_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        res_ovf_next      = res_ovf_reg;
        len_next          = len_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        row_sym_next      = row_sym_reg;
        diag_next         = diag_reg;
        left_next         = left_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        txt_rd_addr       = AW'(i_reg - CW'(1));
        dp_rd_addr        = '0;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (txt_wr_en)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        len_next     = txt_wr_en ? (count_reg + CW'(1)) : count_reg;
                        res_ovf_next = ovf_reg || !txt_wr_en;
                        count_next   = '0;
                        ovf_next     = 1'b0;
                        i_next       = CW'(1);
                        state_next   = ST_ROW_RD;
                    end
                end
            end
            ST_ROW_RD:
            begin
                txt_rd_addr = AW'(i_reg - CW'(1));
                state_next  = ST_ROW_SYM;
            end
            ST_ROW_SYM:
            begin
                row_sym_next = txt_rd_data;
                txt_rd_addr  = AW'(len_reg - CW'(1));
                dp_rd_addr   = '0;
                j_next       = CW'(1);
                diag_next    = '0;
                left_next    = '0;
                state_next   = ST_CELL;
            end
            ST_CELL:
            begin
                diag_next = above;
                left_next = cell_value;
                // fetch the next column while this cell is written back
                txt_rd_addr = AW'(len_reg - j_reg - CW'(1));
                dp_rd_addr  = j_reg[AW-1:0];
                if (j_reg != len_reg)
                begin
                    j_next = j_reg + CW'(1);
                end
                else if (i_reg != len_reg)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_ROW_RD;
                end
                else
                begin
                    result_next.lcs_length = lcs_wide[LCS_W-1:0];
                    result_next.insertions = ins_wide[INS_W-1:0];
                    result_next.overflow   = res_ovf_reg;
                    result_valid_next      = 1'b1;
                    state_next             = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> item_stall)
        else $error("input taken while table sweep runs");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CELL) |-> (j_reg != '0 && j_reg <= len_reg))
        else $error("column index out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CELL) |-> (i_reg != '0 && i_reg <= len_reg))
        else $error("row index out of range");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_CELL))
        else $error("result raised outside the last cell");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LEN))
        else $error("byte count beyond buffer depth");
`endif

endmodule
